// ===== src/vppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vppt_pkg;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int RADIUS_W = 15;
    localparam int R2_W     = 2 * RADIUS_W;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RADIUS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Register index, taken from the word address bit.
    localparam logic REG_INSERT_RADIUS = 1'b0;

    // Reset value of the insert radius, 0.5 in Q7.8.
    localparam logic [RADIUS_W-1:0] INSERT_RADIUS_RESET = 15'd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Control that travels with each point fed into the match unit.
    typedef struct packed {
        logic feed;
        logic rect_mode;
    } match_ctrl_t;

endpackage

`default_nettype wire

// ===== src/vppt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vppt_cell #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                           aclk,
    input  wire                           shift_en,
    input  wire  signed [COORD_WIDTH-1:0] shift_x,
    input  wire  signed [COORD_WIDTH-1:0] shift_y,
    input  wire                           load_en,
    input  wire  signed [COORD_WIDTH-1:0] load_x,
    input  wire  signed [COORD_WIDTH-1:0] load_y,
    output logic signed [COORD_WIDTH-1:0] x,
    output logic signed [COORD_WIDTH-1:0] y
);

    logic signed [COORD_WIDTH-1:0] x_reg, x_next;
    logic signed [COORD_WIDTH-1:0] y_reg, y_next;

    // A new point is written in place; otherwise the ring rotates or holds.
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (load_en) begin
            x_next = load_x;
            y_next = load_y;
        end else if (shift_en) begin
            x_next = shift_x;
            y_next = shift_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

`default_nettype wire

// ===== src/vppt_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vppt_match #(
    parameter int COORD_WIDTH = 16
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire  vppt_pkg::match_ctrl_t        ctrl,
    input  wire  signed [COORD_WIDTH-1:0]      pt_x,
    input  wire  signed [COORD_WIDTH-1:0]      pt_y,
    input  wire  signed [COORD_WIDTH-1:0]      q_x,
    input  wire  signed [COORD_WIDTH-1:0]      q_y,
    input  wire  signed [COORD_WIDTH-1:0]      left,
    input  wire  signed [COORD_WIDTH-1:0]      right,
    input  wire  signed [COORD_WIDTH-1:0]      low,
    input  wire  signed [COORD_WIDTH-1:0]      high,
    input  wire         [vppt_pkg::R2_W-1:0]   r2,
    output logic                               hit
);

    localparam int SQW  = 2 * COORD_WIDTH;
    localparam int SUMW = SQW + 1;
    localparam int CMPW = (SUMW > vppt_pkg::R2_W) ? SUMW : vppt_pkg::R2_W;

    logic signed [COORD_WIDTH:0]   diff_x, diff_y;
    logic        [COORD_WIDTH-1:0] mag_x, mag_y;
    logic                          rect_hit;

    logic                   v1_reg, v1_next;
    logic                   mode1_reg;
    logic                   rect1_reg;
    logic [COORD_WIDTH-1:0] dx1_reg, dy1_reg;

    logic           v2_reg, v2_next;
    logic           mode2_reg;
    logic           rect2_reg;
    logic [SQW-1:0] sqx2_reg, sqy2_reg;

    logic [CMPW-1:0] dist2;
    logic            hit_reg, hit_next;

    // Stage 1: absolute coordinate distances and the rectangle test.
    always_comb begin
        diff_x   = {pt_x[COORD_WIDTH-1], pt_x} - {q_x[COORD_WIDTH-1], q_x};
        diff_y   = {pt_y[COORD_WIDTH-1], pt_y} - {q_y[COORD_WIDTH-1], q_y};
        mag_x    = diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
        mag_y    = diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
        rect_hit = (pt_x >= left) && (pt_x <= right) && (pt_y > low) && (pt_y < high);
        v1_next  = ctrl.feed;
    end

    // Stage 2: square both distances.
    assign v2_next = v1_reg;

    // Stage 3: squared distance against squared radius, or the rectangle flag.
    always_comb begin
        dist2    = CMPW'(sqx2_reg) + CMPW'(sqy2_reg);
        hit_next = v2_reg && (mode2_reg ? rect2_reg : (dist2 < CMPW'(r2)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode1_reg <= ctrl.rect_mode;
        rect1_reg <= rect_hit;
        dx1_reg   <= mag_x;
        dy1_reg   <= mag_y;
        mode2_reg <= mode1_reg;
        rect2_reg <= rect1_reg;
        sqx2_reg  <= SQW'(dx1_reg) * SQW'(dx1_reg);
        sqy2_reg  <= SQW'(dy1_reg) * SQW'(dy1_reg);
    end

    assign hit = hit_reg;

    // A hit can only come out for a point that was fed in and has passed through the pipeline stages.
    a_hit_from_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg |-> $past(ctrl.feed, 3))
        else $error("match hit without a fed point");

endmodule

`default_nettype wire

// ===== src/visited_point_proximity_table_top.sv =====
// Only one transaction is in flight at a time; the stored points make one full
// turn of the cell ring past a single three-stage distance unit.
// Reset (aresetn low, synchronous) empties the table, restores the insert
// radius to 0.5 and clears any pending result. Point storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module visited_point_proximity_table_top #(
    parameter int CAPACITY    = 256,
    parameter int COORD_WIDTH = 16
) (
    input  wire                                         aclk,
    input  wire                                         aresetn,

    input  wire                                         psel,
    input  wire                                         penable,
    input  wire                                         pwrite,
    input  wire  [vppt_pkg::APB_AW-1:0]                 paddr,
    input  wire  [vppt_pkg::APB_DW-1:0]                 pwdata,
    output logic [vppt_pkg::APB_DW-1:0]                 prdata,
    output logic                                        pready,

    input  wire                                         s_valid,
    output logic                                        s_ready,
    input  wire  [vppt_pkg::CMD_W-1:0]                  s_cmd,
    input  wire  signed [COORD_WIDTH-1:0]               s_pos_x,
    input  wire  signed [COORD_WIDTH-1:0]               s_pos_y,
    input  wire  signed [COORD_WIDTH-1:0]               s_corner_x,
    input  wire  signed [COORD_WIDTH-1:0]               s_corner_y,
    input  wire  [vppt_pkg::RADIUS_W-1:0]               s_query_radius,

    output logic                                        m_valid,
    input  wire                                         m_ready,
    output logic                                        m_found,
    output logic                                        m_inserted,
    output logic                                        m_table_full,
    output logic [$clog2(CAPACITY+1)-1:0]               m_stored_count
);

    localparam int CNTW  = $clog2(CAPACITY + 1);
    localparam int STEPW = $clog2(CAPACITY + 3);
    localparam logic [STEPW-1:0] LAST_STEP = STEPW'(CAPACITY + 2);

    // Configuration register.
    logic [vppt_pkg::RADIUS_W-1:0] insert_radius_reg, insert_radius_next;

    // Control state.
    vppt_pkg::state_t      state_reg, state_next;
    logic [STEPW-1:0]      step_reg, step_next;
    logic [CNTW-1:0]       count_reg, count_next;
    logic                  found_reg, found_next;

    // Latched transaction.
    logic [vppt_pkg::CMD_W-1:0]    cmd_reg;
    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic signed [COORD_WIDTH-1:0] left_reg, right_reg, low_reg, high_reg;
    logic [vppt_pkg::RADIUS_W-1:0] radius_reg;
    logic [vppt_pkg::R2_W-1:0]     r2_reg;

    // Result register.
    logic            m_valid_reg, m_valid_next;
    logic            m_found_reg, m_inserted_reg, m_table_full_reg;
    logic [CNTW-1:0] m_count_reg;

    logic                  accept;
    logic                  out_free;
    logic                  shift_en;
    logic                  commit;
    logic                  is_add;
    logic                  do_insert;
    logic                  drop_full;
    logic                  hit;
    vppt_pkg::match_ctrl_t match_ctrl;

    logic signed [COORD_WIDTH-1:0] cell_x [CAPACITY];
    logic signed [COORD_WIDTH-1:0] cell_y [CAPACITY];

    // APB register access.
    assign pready = 1'b1;

    always_comb begin
        insert_radius_next = insert_radius_reg;
        if (psel && penable && pwrite && pready
                && (paddr[2] == vppt_pkg::REG_INSERT_RADIUS)) begin
            insert_radius_next = pwdata[vppt_pkg::RADIUS_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == vppt_pkg::REG_INSERT_RADIUS) begin
            prdata = vppt_pkg::APB_DW'(insert_radius_reg);
        end
    end

    // Sequencer: accept, rotate the ring once through the match unit, drain, commit.
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        s_ready         = 1'b0;
        shift_en        = 1'b0;
        commit          = 1'b0;
        match_ctrl.feed = 1'b0;
        match_ctrl.rect_mode = (cmd_reg == vppt_pkg::CMD_RECT);
        unique case (state_reg)
            vppt_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = vppt_pkg::ST_SCAN;
                    step_next  = '0;
                end
            end
            vppt_pkg::ST_SCAN: begin
                shift_en        = (step_reg < STEPW'(CAPACITY));
                match_ctrl.feed = shift_en && (step_reg < STEPW'(count_reg))
                                  && (cmd_reg != vppt_pkg::CMD_NONE);
                step_next       = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = vppt_pkg::ST_FINISH;
                end
            end
            vppt_pkg::ST_FINISH: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = vppt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vppt_pkg::ST_IDLE;
            end
        endcase
    end

    // Any hit from the match unit sets the found flag for this transaction.
    assign found_next = accept ? 1'b0 : (found_reg || hit);

    // Add decision and count update.
    always_comb begin
        is_add     = (cmd_reg == vppt_pkg::CMD_ADD);
        do_insert  = is_add && !found_reg && (count_reg < CNTW'(CAPACITY));
        drop_full  = is_add && !found_reg && (count_reg >= CNTW'(CAPACITY));
        count_next = count_reg;
        if (commit && do_insert) begin
            count_next = count_reg + 1'b1;
        end
    end

    // Result register, freed when the transaction is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            insert_radius_reg <= vppt_pkg::INSERT_RADIUS_RESET;
            state_reg         <= vppt_pkg::ST_IDLE;
            step_reg          <= '0;
            count_reg         <= '0;
            found_reg         <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            insert_radius_reg <= insert_radius_next;
            state_reg         <= state_next;
            step_reg          <= step_next;
            count_reg         <= count_next;
            found_reg         <= found_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Transaction fields, rectangle bounds and the squared radius.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= s_cmd;
            qx_reg     <= s_pos_x;
            qy_reg     <= s_pos_y;
            left_reg   <= (s_pos_x < s_corner_x) ? s_pos_x : s_corner_x;
            right_reg  <= (s_pos_x < s_corner_x) ? s_corner_x : s_pos_x;
            low_reg    <= (s_pos_y < s_corner_y) ? s_pos_y : s_corner_y;
            high_reg   <= (s_pos_y < s_corner_y) ? s_corner_y : s_pos_y;
            radius_reg <= (s_cmd == vppt_pkg::CMD_ADD) ? insert_radius_reg : s_query_radius;
        end
        r2_reg <= vppt_pkg::R2_W'(radius_reg) * vppt_pkg::R2_W'(radius_reg);
        if (commit) begin
            m_found_reg      <= found_reg;
            m_inserted_reg   <= do_insert;
            m_table_full_reg <= drop_full;
            m_count_reg      <= count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_inserted     = m_inserted_reg;
    assign m_table_full   = m_table_full_reg;
    assign m_stored_count = m_count_reg;

    // Ring of point cells; cell 0 is the head seen by the match unit.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        vppt_cell #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .shift_en (shift_en),
            .shift_x  (cell_x[(i + 1) % CAPACITY]),
            .shift_y  (cell_y[(i + 1) % CAPACITY]),
            .load_en  (commit && do_insert && (count_reg == CNTW'(i))),
            .load_x   (qx_reg),
            .load_y   (qy_reg),
            .x        (cell_x[i]),
            .y        (cell_y[i])
        );
    end

    // Distance and rectangle match unit.
    vppt_match #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (match_ctrl),
        .pt_x    (cell_x[0]),
        .pt_y    (cell_y[0]),
        .q_x     (qx_reg),
        .q_y     (qy_reg),
        .left    (left_reg),
        .right   (right_reg),
        .low     (low_reg),
        .high    (high_reg),
        .r2      (r2_reg),
        .hit     (hit)
    );

    // The table never holds more points than it has cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNTW'(CAPACITY))
        else $error("point count above capacity");

    // The count only changes when a transaction is committed.
    a_count_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(count_reg))
        else $error("point count changed outside commit");

    // A result never reports more than one outcome of an add.
    a_outcome_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_inserted_reg && m_table_full_reg)
                        && !(m_inserted_reg && m_found_reg))
        else $error("conflicting result flags");

    // No new transaction is taken while one is in flight.
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != vppt_pkg::ST_IDLE) |-> !s_ready)
        else $error("input ready while busy");

endmodule

`default_nettype wire
